FILE: hw/rtl/imu_dr_pkg.sv
// Shared types and constants for the IMU dead-reckoning integrator.
`default_nettype none

package imu_dr_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_RECIP,
      ST_SAT,
      ST_ADT,
      ST_ADT2,
      ST_VDT,
      ST_SUM,
      ST_UPD,
      ST_DONE
   } seq_state_type;

   typedef enum logic [0:0] {
      CSR_GRAVITY  = 1'b0,
      CSR_FRICTION = 1'b1
   } csr_index_type;

   localparam int GRAV_W = 8;
   localparam int FRIC_W = 16;
   localparam int CSR_W  = 16;
   localparam int MG_W   = 15;
   localparam int ACC_W  = 13;
   localparam int DT_W   = 16;
   localparam int VEL_W  = 32;
   localparam int POS_W  = 64;
   localparam int ADT_W  = 29;
   localparam int DP_W   = 50;
   localparam int MA_W   = 33;
   localparam int MB_W   = 24;
   localparam int MP_W   = MA_W + MB_W;

   localparam logic [GRAV_W-1:0] GRAVITY_RST  = 8'd98;
   localparam logic [FRIC_W-1:0] FRICTION_RST = 16'd2000;

   // ceil(2^32 / 1000): exact floor division by 1000 for inputs below 2^22
   localparam logic [22:0] RECIP_1000 = 23'd4294968;
   localparam logic [22:0] ROUND_HALF = 23'd500;
   localparam logic [ACC_W-1:0] ACC_POS_LIM = 13'd4095;
   localparam logic [ACC_W-1:0] ACC_NEG_LIM = 13'd4096;

endpackage

`default_nettype wire

FILE: hw/rtl/imu_dead_reckoning_integrator_unit.sv
// IMU dead-reckoning integrator: shared-multiplier sequencer and state registers.
//
//  channel  direction  handshake             beat
//  req      in         req_valid/req_ready   start flag, timestamp, x/y accel in mg
//  rsp      out        rsp_valid/rsp_ready   x/y accel in tenths, velocity, position
//  csr      in         csr_we                register index, write data
//
//  A start beat gives no response and leaves the sequencer idle.
//  A sample beat steps each axis from CONV to UPD, then loads the output in DONE;
//  the one 33x24 multiplier is shared by all five products per axis.
//  req_ready is high only while the sequencer idles; the response register
//  lets the next beat enter while a response waits.
//  Synchronous active-high reset restores both CSRs and clears all motion state.
`default_nettype none

module imu_dead_reckoning_integrator_unit (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_ready,
   input  wire                                       req_start_req,
   input  wire  [31:0]                               req_now_ms,
   input  wire  signed [imu_dr_pkg::MG_W-1:0]        req_accel_x_mg,
   input  wire  signed [imu_dr_pkg::MG_W-1:0]        req_accel_y_mg,
   output logic                                      rsp_valid,
   input  wire                                       rsp_ready,
   output logic signed [imu_dr_pkg::ACC_W-1:0]       rsp_accel_x_tenths,
   output logic signed [imu_dr_pkg::ACC_W-1:0]       rsp_accel_y_tenths,
   output logic signed [imu_dr_pkg::VEL_W-1:0]       rsp_vel_x,
   output logic signed [imu_dr_pkg::VEL_W-1:0]       rsp_vel_y,
   output logic signed [imu_dr_pkg::POS_W-1:0]       rsp_pos_x,
   output logic signed [imu_dr_pkg::POS_W-1:0]       rsp_pos_y,
   input  wire                                       csr_we,
   input  wire  [0:0]                                csr_index,
   input  wire  [imu_dr_pkg::CSR_W-1:0]              csr_wdata
);
   import imu_dr_pkg::*;

   seq_state_type state_ff, state_in;

   logic [GRAV_W-1:0] grav_ff;
   logic [FRIC_W-1:0] fric_ff;
   logic [31:0]       last_time_ff;
   logic signed [VEL_W-1:0] vel_x_ff, vel_y_ff;
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic              axis_ff;
   logic              rsp_valid_ff;

   logic signed [MG_W-1:0]  mg_x_ff, mg_y_ff;
   logic [DT_W-1:0]         dt_ff;
   logic signed [MP_W-1:0]  prod_ff;
   logic                    neg_ff;
   logic signed [ACC_W-1:0] acc_x_ff, acc_y_ff;
   logic signed [ADT_W-1:0] adt_ff;
   logic signed [DP_W-1:0]  dp_ff;
   logic signed [VEL_W-1:0] vsat_ff;

   logic signed [ACC_W-1:0] rsp_acc_x_ff, rsp_acc_y_ff;
   logic signed [VEL_W-1:0] rsp_vel_x_ff, rsp_vel_y_ff;
   logic signed [POS_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff;

   logic                    accept;
   logic                    slot_free;
   logic [31:0]             diff;
   logic [DT_W-1:0]         dt_new;
   logic signed [MG_W-1:0]  mg_sel;
   logic signed [ACC_W-1:0] acc_sel;
   logic signed [VEL_W-1:0] vel_sel;
   logic signed [POS_W-1:0] pos_sel;
   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic signed [MP_W-1:0]  mul_p;
   logic [22:0]             prod_lo;
   logic [22:0]             mag;
   logic [22:0]             conv_x;
   logic [ACC_W-1:0]        quot;
   logic signed [ACC_W-1:0] acc_sat;
   logic [VEL_W:0]          v_sum;
   logic signed [VEL_W-1:0] v_clamp;
   logic [VEL_W:0]          v_neg;
   logic [VEL_W:0]          fric_ext;
   logic signed [VEL_W-1:0] v_fric;
   logic [POS_W:0]          p_sum;
   logic signed [POS_W-1:0] p_clamp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign diff   = req_now_ms - last_time_ff;
   assign dt_new = (diff[31:DT_W] != '0) ? {DT_W{1'b1}} : diff[DT_W-1:0];

   assign mg_sel  = axis_ff ? mg_y_ff  : mg_x_ff;
   assign acc_sel = axis_ff ? acc_y_ff : acc_x_ff;
   assign vel_sel = axis_ff ? vel_y_ff : vel_x_ff;
   assign pos_sel = axis_ff ? pos_y_ff : pos_x_ff;

   // rounding: |mg * g| + 500, then floor-divide by 1000 via reciprocal
   assign prod_lo = prod_ff[22:0];
   assign mag     = prod_ff[MP_W-1] ? (23'd0 - prod_lo) : prod_lo;
   assign conv_x  = {1'b0, mag[21:0]} + ROUND_HALF;
   assign quot    = prod_ff[44:32];

   always_comb begin
      if (neg_ff) begin
         acc_sat = (quot > ACC_NEG_LIM) ? $signed(ACC_NEG_LIM) : $signed(13'd0 - quot);
      end else begin
         acc_sat = (quot > ACC_POS_LIM) ? $signed(ACC_POS_LIM) : $signed(quot);
      end
   end

   always_comb begin
      case (state_ff)
         ST_CONV: begin
            mul_a = MA_W'(mg_sel);
            mul_b = {{(MB_W-GRAV_W){1'b0}}, grav_ff};
         end
         ST_RECIP: begin
            mul_a = {10'd0, conv_x};
            mul_b = {1'b0, RECIP_1000};
         end
         ST_ADT: begin
            mul_a = MA_W'(acc_sel);
            mul_b = {{(MB_W-DT_W){1'b0}}, dt_ff};
         end
         ST_ADT2: begin
            mul_a = MA_W'($signed(prod_ff[ADT_W-1:0]));
            mul_b = {{(MB_W-DT_W){1'b0}}, dt_ff};
         end
         ST_VDT: begin
            mul_a = MA_W'(vel_sel);
            mul_b = {{(MB_W-DT_W){1'b0}}, dt_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // velocity: v + a*dt, clamp to 32 bits
   assign v_sum   = {vel_sel[VEL_W-1], vel_sel} + (VEL_W+1)'(adt_ff);
   assign v_clamp = (v_sum[VEL_W] != v_sum[VEL_W-1])
                    ? (v_sum[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}})
                    : v_sum[VEL_W-1:0];

   // friction toward zero
   assign fric_ext = {{(VEL_W+1-FRIC_W){1'b0}}, fric_ff};
   assign v_neg    = (VEL_W+1)'(0) - {vsat_ff[VEL_W-1], vsat_ff};

   always_comb begin
      if (vsat_ff[VEL_W-1]) begin
         v_fric = (v_neg < fric_ext) ? '0 : vsat_ff + VEL_W'(fric_ff);
      end else begin
         v_fric = ({1'b0, vsat_ff} < fric_ext) ? '0 : vsat_ff - VEL_W'(fric_ff);
      end
   end

   // position: p + dp, clamp to 64 bits
   assign p_sum   = {pos_sel[POS_W-1], pos_sel} + (POS_W+1)'(dp_ff);
   assign p_clamp = (p_sum[POS_W] != p_sum[POS_W-1])
                    ? (p_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}})
                    : p_sum[POS_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && !req_start_req) state_in = ST_CONV;
         ST_CONV:  state_in = ST_RECIP;
         ST_RECIP: state_in = ST_SAT;
         ST_SAT:   state_in = ST_ADT;
         ST_ADT:   state_in = ST_ADT2;
         ST_ADT2:  state_in = ST_VDT;
         ST_VDT:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_UPD;
         ST_UPD:   state_in = axis_ff ? ST_DONE : ST_CONV;
         ST_DONE:  if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grav_ff      <= GRAVITY_RST;
         fric_ff      <= FRICTION_RST;
         last_time_ff <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_GRAVITY:  grav_ff <= csr_wdata[GRAV_W-1:0];
               CSR_FRICTION: fric_ff <= csr_wdata[FRIC_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            last_time_ff <= req_now_ms;
            axis_ff      <= 1'b0;
            if (req_start_req) begin
               vel_x_ff <= '0;
               vel_y_ff <= '0;
               pos_x_ff <= '0;
               pos_y_ff <= '0;
            end
         end
         if (state_ff == ST_UPD) begin
            axis_ff <= ~axis_ff;
            if (axis_ff) begin
               vel_y_ff <= v_fric;
               pos_y_ff <= p_clamp;
            end else begin
               vel_x_ff <= v_fric;
               pos_x_ff <= p_clamp;
            end
         end
         if (state_ff == ST_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dt_ff   <= dt_new;
               mg_x_ff <= req_accel_x_mg;
               mg_y_ff <= req_accel_y_mg;
            end
         end
         ST_CONV: prod_ff <= mul_p;
         ST_RECIP: begin
            prod_ff <= mul_p;
            neg_ff  <= prod_ff[MP_W-1];
         end
         ST_SAT: begin
            if (axis_ff) acc_y_ff <= acc_sat;
            else         acc_x_ff <= acc_sat;
         end
         ST_ADT: prod_ff <= mul_p;
         ST_ADT2: begin
            adt_ff  <= prod_ff[ADT_W-1:0];
            prod_ff <= mul_p;
         end
         ST_VDT: begin
            dp_ff   <= prod_ff[DP_W-1:0];
            prod_ff <= mul_p;
         end
         ST_SUM: begin
            dp_ff   <= dp_ff + {prod_ff[DP_W-2:0], 1'b0};
            vsat_ff <= v_clamp;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_acc_x_ff <= acc_x_ff;
               rsp_acc_y_ff <= acc_y_ff;
               rsp_vel_x_ff <= vel_x_ff;
               rsp_vel_y_ff <= vel_y_ff;
               rsp_pos_x_ff <= pos_x_ff;
               rsp_pos_y_ff <= pos_y_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accel_x_tenths = rsp_acc_x_ff;
   assign rsp_accel_y_tenths = rsp_acc_y_ff;
   assign rsp_vel_x          = rsp_vel_x_ff;
   assign rsp_vel_y          = rsp_vel_y_ff;
   assign rsp_pos_x          = rsp_pos_x_ff;
   assign rsp_pos_y          = rsp_pos_y_ff;

   a_sample_starts_x: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_start_req) |=> (state_ff == ST_CONV && !axis_ff))
      else $error("sample beat did not start on x axis");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_start_req) |=> (vel_x_ff == '0 && vel_y_ff == '0 &&
                                     pos_x_ff == '0 && pos_y_ff == '0 &&
                                     state_ff == ST_IDLE))
      else $error("start beat did not clear motion state");

   a_y_then_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && axis_ff) |=> (state_ff == ST_DONE && !axis_ff))
      else $error("sequencer skipped output load after y axis");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && slot_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("response not posted on completion");

   a_no_busy_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_DONE) |=> !$rose(rsp_valid_ff))
      else $error("response posted mid-sequence");

endmodule

`default_nettype wire

FILE: bench/imu_dead_reckoning_integrator_unit_test.sv
// Self-checking bench for the IMU dead-reckoning integrator: directed table, random trips, soak.
`timescale 1ns / 1ps

module imu_dead_reckoning_integrator_unit_test;
   import imu_dr_pkg::*;

   typedef struct packed {
      logic                    start;
      logic [31:0]             now;
      logic signed [MG_W-1:0]  ax;
      logic signed [MG_W-1:0]  ay;
   } imu_beat_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] ax;
      logic signed [ACC_W-1:0] ay;
      logic signed [VEL_W-1:0] vx;
      logic signed [VEL_W-1:0] vy;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
   } nav_fix_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} plan_kind_type;

   typedef struct packed {
      plan_kind_type           kind;
      logic                    start;
      logic [31:0]             now;
      logic signed [MG_W-1:0]  ax;
      logic signed [MG_W-1:0]  ay;
      logic                    typed;
      nav_fix_type             fix;
      csr_index_type           idx;
      logic [CSR_W-1:0]        data;
   } plan_row_type;

   typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_TRICKLE, DRAIN_HALT} drain_mode_type;

   localparam longint POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint POS_MIN = 64'sh8000_0000_0000_0000;
   localparam longint VEL_MAX = 64'sd2147483647;
   localparam longint VEL_MIN = -64'sd2147483648;
   localparam longint DT_CAP  = 65535;
   localparam longint ACC_HI  = 4095;
   localparam longint ACC_LO  = -4096;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_start_req = 1'b0;
   logic [31:0]                req_now_ms = '0;
   logic signed [MG_W-1:0]     req_accel_x_mg = '0;
   logic signed [MG_W-1:0]     req_accel_y_mg = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [ACC_W-1:0]    rsp_accel_x_tenths;
   logic signed [ACC_W-1:0]    rsp_accel_y_tenths;
   logic signed [VEL_W-1:0]    rsp_vel_x;
   logic signed [VEL_W-1:0]    rsp_vel_y;
   logic signed [POS_W-1:0]    rsp_pos_x;
   logic signed [POS_W-1:0]    rsp_pos_y;
   logic                       csr_we = 1'b0;
   logic [0:0]                 csr_index = '0;
   logic [CSR_W-1:0]           csr_wdata = '0;

   // predictor state
   logic [GRAV_W-1:0]          grav_reg = GRAVITY_RST;
   logic [FRIC_W-1:0]          fric_reg = FRICTION_RST;
   logic [31:0]                nav_last = '0;
   logic signed [VEL_W-1:0]    nav_vel [2] = '{0, 0};
   logic signed [POS_W-1:0]    nav_pos [2] = '{0, 0};

   nav_fix_type                fixes_due [$];
   plan_row_type               plan [$];
   int                         mismatches = 0;
   int                         burst_left = 0;
   bit                         soak_on = 1'b0;
   logic [31:0]                stamp = '0;

   imu_dead_reckoning_integrator_unit u_dut (.*);

   always #1 clock = ~clock;

   function automatic logic signed [ACC_W-1:0] mg_to_tenths(input logic signed [MG_W-1:0] mg);
      longint num, mag, q;
      num = longint'(mg) * longint'(grav_reg);
      mag = (num < 0) ? -num : num;
      q = (mag + 500) / 1000;
      if (num < 0) q = -q;
      if (q > ACC_HI) q = ACC_HI;
      if (q < ACC_LO) q = ACC_LO;
      return q[ACC_W-1:0];
   endfunction

   function automatic void step_axis(input int k, input longint a, input longint dt);
      longint vo, vn, dp, f;
      logic signed [POS_W+1:0] sum;
      vo = nav_vel[k];
      f = fric_reg;
      dp = 2 * vo * dt + a * dt * dt;
      vn = vo + a * dt;
      sum = nav_pos[k];
      sum = sum + dp;
      if (sum > POS_MAX) nav_pos[k] = POS_MAX;
      else if (sum < POS_MIN) nav_pos[k] = POS_MIN;
      else nav_pos[k] = sum[POS_W-1:0];
      if (vn > VEL_MAX) vn = VEL_MAX;
      if (vn < VEL_MIN) vn = VEL_MIN;
      if (vn < 0) vn = vn + ((-vn < f) ? -vn : f);
      else vn = vn - ((vn < f) ? vn : f);
      nav_vel[k] = vn[VEL_W-1:0];
   endfunction

   function automatic void advance_nav(input imu_beat_type b, output bit emits,
                                       output nav_fix_type fix);
      logic [31:0]             span_ms;
      longint                  dt;
      logic signed [ACC_W-1:0] ax, ay;
      fix = '0;
      emits = 1'b0;
      if (b.start) begin
         nav_vel = '{0, 0};
         nav_pos = '{0, 0};
         nav_last = b.now;
         return;
      end
      span_ms = b.now - nav_last;
      dt = (span_ms > DT_CAP) ? DT_CAP : span_ms;
      nav_last = b.now;
      ax = mg_to_tenths(b.ax);
      ay = mg_to_tenths(b.ay);
      step_axis(0, ax, dt);
      step_axis(1, ay, dt);
      fix.ax = ax;
      fix.ay = ay;
      fix.vx = nav_vel[0];
      fix.vy = nav_vel[1];
      fix.px = nav_pos[0];
      fix.py = nav_pos[1];
      emits = 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic logic signed [MG_W-1:0] rand_mg(input int bias);
      int v, pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         v = $urandom_range(0, 600);
         v = bias + v - 300;
         if (v > 16000) v = 16000;
         if (v < -16000) v = -16000;
      end else if (pick < 80) begin
         v = $urandom_range(0, 32000);
         v -= 16000;
      end else if (pick < 90) begin
         v = $urandom;
      end else begin
         case ($urandom_range(0, 4))
            0: v = 16383;
            1: v = -16384;
            2: v = 16000;
            3: v = -16000;
            default: v = 0;
         endcase
      end
      return v[MG_W-1:0];
   endfunction

   function automatic logic [31:0] next_stamp();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) stamp += $urandom_range(0, 120);
      else if (pick < 75) stamp += $urandom_range(121, 65535);
      else if (pick < 85) stamp += $urandom_range(32'hFFFF_FFFF, 32'h0001_0000);
      else if (pick < 93) stamp -= $urandom_range(1, 5000);
      else stamp = $urandom;
      return stamp;
   endfunction

   function automatic void plan_beat(input bit start, input logic [31:0] now, input int ax,
                                     input int ay, input bit typed = 1'b0,
                                     input nav_fix_type fix = '0);
      plan_row_type row;
      row = '0;
      row.kind = ROW_BEAT;
      row.start = start;
      row.now = now;
      row.ax = ax[MG_W-1:0];
      row.ay = ay[MG_W-1:0];
      row.typed = typed;
      row.fix = fix;
      plan.push_back(row);
   endfunction

   function automatic void plan_csr(input csr_index_type idx, input logic [CSR_W-1:0] data);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.idx = idx;
      row.data = data;
      plan.push_back(row);
   endfunction

   task automatic pace();
      int idle;
      if (soak_on) return;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            idle = $urandom_range(1, 12);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (idle - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_beat(input bit start, input logic [31:0] now,
                            input logic signed [MG_W-1:0] ax, input logic signed [MG_W-1:0] ay,
                            input bit typed = 1'b0, input nav_fix_type fix = '0);
      imu_beat_type b;
      bit           emits;
      nav_fix_type  predicted;
      b.start = start;
      b.now = now;
      b.ax = ax;
      b.ay = ay;
      pace();
      @(negedge clock);
      req_valid <= 1'b1;
      req_start_req <= start;
      req_now_ms <= now;
      req_accel_x_mg <= ax;
      req_accel_y_mg <= ay;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_nav(b, emits, predicted);
      if (emits) fixes_due.push_back(typed ? fix : predicted);
   endtask

   // drop valid, wait for every pending beat, then let a start finish
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (fixes_due.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_GRAVITY:  grav_reg = data[GRAV_W-1:0];
         CSR_FRICTION: fric_reg = data[FRIC_W-1:0];
         default: ;
      endcase
   endtask

   task automatic run_phase(input int quota);
      int done_n, pick, len, bx, by;
      done_n = 0;
      while (done_n < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_beat(1'b1, $urandom, rand_mg(0), rand_mg(0));
            done_n++;
         end else if (pick < 90) begin
            bx = $urandom_range(0, 32000);
            bx -= 16000;
            by = $urandom_range(0, 32000);
            by -= 16000;
            send_beat(1'b1, next_stamp(), rand_mg(bx), rand_mg(by));
            len = $urandom_range(3, 40);
            repeat (len) send_beat(1'b0, next_stamp(), rand_mg(bx), rand_mg(by));
            done_n += len + 1;
         end else begin
            len = $urandom_range(1, 5);
            repeat (len) send_beat(1'b0, $urandom, MG_W'($urandom), MG_W'($urandom));
            done_n += len;
         end
      end
   endtask

   always @(posedge clock) begin : rsp_check
      nav_fix_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (fixes_due.size() == 0) begin
            $display("%0t ns: response beat with nothing pending, pos_x %0d", $time, rsp_pos_x);
            mismatches++;
         end else begin
            want = fixes_due.pop_front();
            check_field("accel_x_tenths", want.ax, rsp_accel_x_tenths);
            check_field("accel_y_tenths", want.ay, rsp_accel_y_tenths);
            check_field("vel_x", want.vx, rsp_vel_x);
            check_field("vel_y", want.vy, rsp_vel_y);
            check_field("pos_x", want.px, rsp_pos_x);
            check_field("pos_y", want.py, rsp_pos_y);
         end
      end
   end

   initial begin : drain_side
      drain_mode_type mode;
      int             span;
      forever begin
         mode = drain_mode_type'($urandom_range(0, 3));
         span = $urandom_range(4, 60);
         repeat (span) begin
            @(negedge clock);
            if (soak_on || mode == DRAIN_FREE) rsp_ready <= 1'b1;
            else if (mode == DRAIN_COIN) rsp_ready <= 1'($urandom_range(0, 1));
            else if (mode == DRAIN_TRICKLE) rsp_ready <= ($urandom_range(0, 7) == 0);
            else rsp_ready <= 1'b0;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int g, f;

      plan_beat(1'b0, 32'd0, 0, 0, 1'b1, '0);
      plan_beat(1'b0, 32'd10, 1000, -1000, 1'b1, nav_fix_type'{98, -98, 0, 0, 9800, -9800});
      plan_beat(1'b1, 32'd1000, 7, -7);
      plan_beat(1'b0, 32'd1250, 250, -250);
      plan_beat(1'b0, 32'd1250, 16383, -16384);
      plan_beat(1'b0, 32'd1300, -16000, 16000);
      plan_csr(CSR_GRAVITY, 16'hA5FF);
      plan_csr(CSR_FRICTION, 16'h0000);
      plan_beat(1'b1, 32'hFFFF_FFF0, 0, 0);
      plan_beat(1'b0, 32'hFFFF_FFF0, 16383, -16384, 1'b1,
                nav_fix_type'{4095, -4096, 0, 0, 0, 0});
      plan_beat(1'b0, 32'h0000_0010, 16000, -16000);
      for (int k = 1; k <= 9; k++) plan_beat(1'b0, k * 32'h0100_0000, 16383, -16384);
      plan_csr(CSR_FRICTION, 16'hFFFF);
      plan_beat(1'b0, 32'h0900_0100, 0, 0);
      plan_csr(CSR_GRAVITY, 16'h5A64);
      plan_beat(1'b0, 32'h0900_0101, -5, 5);
      plan_beat(1'b0, 32'h0900_0102, 15, -15);
      plan_csr(CSR_GRAVITY, 16'hFF00);
      plan_beat(1'b0, 32'h0900_0200, 16383, -16384);
      plan_beat(1'b1, 32'd0, 0, 0);
      plan_beat(1'b0, 32'hFFFF_FFFF, 1, -1);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            csr_write(plan[i].idx, plan[i].data);
         end else begin
            send_beat(plan[i].start, plan[i].now, plan[i].ax, plan[i].ay,
                      plan[i].typed, plan[i].fix);
         end
      end

      for (int p = 0; p < 7; p++) begin
         g = (p == 0) ? 98 : (p == 1) ? 255 : (p == 2) ? 0 : $urandom_range(0, 255);
         f = (p == 0) ? 2000 : (p == 1) ? 0 : (p == 2) ? 65535 : (p == 3) ? 1
                            : $urandom_range(0, 8000);
         settle();
         csr_write(CSR_GRAVITY, {8'($urandom), 8'(g)});
         csr_write(CSR_FRICTION, 16'(f));
         run_phase(240);
      end

      // full-scale drive back to back, velocities pinned at their limits
      settle();
      csr_write(CSR_GRAVITY, 16'h00FF);
      csr_write(CSR_FRICTION, 16'h0000);
      soak_on = 1'b1;
      stamp = 32'h8000_0000;
      send_beat(1'b1, stamp, '0, '0);
      repeat (32) begin
         stamp += 32'h0001_0000;
         send_beat(1'b0, stamp, 15'sd16383, -15'sd16384);
      end
      repeat (4) begin
         stamp += 32'h0001_0000;
         send_beat(1'b0, stamp, -15'sd16384, 15'sd16383);
      end
      soak_on = 1'b0;

      settle();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && fixes_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/imu_dr_pkg.sv
hw/rtl/imu_dead_reckoning_integrator_unit.sv
bench/imu_dead_reckoning_integrator_unit_test.sv
